### hw/rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// Page replacement package
// Shared sizes, policy codes, controller states and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int FRAMES     = 4;
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int PAGE_WIDTH = 8;
    localparam int STAMP_W    = 16;
    localparam int ADDR_W     = 10;
    localparam int OFFSET_W   = 4;
    localparam int FRAME_OUT_W = 2;

    localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAMES - 1);
    localparam logic [STAMP_W-1:0] FAULT_MAX  = {STAMP_W{1'b1}};

    typedef enum logic [1:0] {
        POLICY_FIFO  = 2'd0,
        POLICY_LRU   = 2'd1,
        POLICY_CLOCK = 2'd2,
        POLICY_RSVD  = 2'd3
    } t_policy;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_CLOCK,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic scan_step;
        logic clock_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic found;
        logic clock_mode;
        logic hand_ref;
        logic scan_last;
    } t_status;

endpackage

### hw/rtl/prp_ctrl.sv
// ----------------------------------------------------------------------------
// Page replacement controller
// Sequences one access at a time through lookup, victim search and commit,
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module prp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  prp_pkg::t_status i_status,
    output prp_pkg::t_cmd    o_cmd
);
    import prp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (i_status.hit || i_status.found) begin
                    n_state = S_UPDATE;
                end else if (i_status.clock_mode) begin
                    n_state = S_CLOCK;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_CLOCK: begin
                o_cmd.clock_step = 1'b1;
                if (!i_status.hand_ref) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // The result register must be free before the frame state moves on.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/prp_dpath.sv
// ----------------------------------------------------------------------------
// Page replacement datapath
// Frame table, timestamps, clock hand, fault counter, policy register, the
// age compare unit shared over frames and the result register.
// ----------------------------------------------------------------------------
module prp_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_data,
    input  logic [prp_pkg::ADDR_W-1:0]          i_instr_address,
    input  logic [prp_pkg::PAGE_WIDTH-1:0]      i_page,
    input  prp_pkg::t_cmd                       i_cmd,
    output prp_pkg::t_status                    o_status,
    output logic                                o_hit,
    output logic [prp_pkg::FRAME_OUT_W-1:0]     o_frame,
    output logic [prp_pkg::OFFSET_W-1:0]        o_offset,
    output logic                                o_evicted,
    output logic [prp_pkg::PAGE_WIDTH-1:0]      o_evicted_page,
    output logic [prp_pkg::STAMP_W-1:0]         o_fault_count
);
    import prp_pkg::*;

    // Frame table.
    logic [PAGE_WIDTH-1:0] r_frame_page [FRAMES];
    logic [FRAMES-1:0]     r_frame_valid;
    logic [STAMP_W-1:0]    r_load_time  [FRAMES];
    logic [STAMP_W-1:0]    r_last_use   [FRAMES];
    logic [FRAMES-1:0]     r_ref_bit;

    logic [FRAME_W-1:0]    r_clock_hand;
    logic [STAMP_W-1:0]    r_access_counter;
    logic [STAMP_W-1:0]    r_faults;
    t_policy               r_policy;

    // Current access.
    logic [ADDR_W-1:0]     r_addr;
    logic [PAGE_WIDTH-1:0] r_page;
    logic                  r_hit;
    logic                  r_evict;
    logic [FRAME_W-1:0]    r_slot;
    logic [OFFSET_W-1:0]   r_offset;
    logic [FRAME_W-1:0]    r_idx;
    logic [STAMP_W-1:0]    r_best_age;

    // Result register.
    logic                  r_o_hit;
    logic [FRAME_OUT_W-1:0] r_o_frame;
    logic [OFFSET_W-1:0]   r_o_offset;
    logic                  r_o_evicted;
    logic [PAGE_WIDTH-1:0] r_o_evicted_page;
    logic [STAMP_W-1:0]    r_o_fault_count;

    logic                  hit_any;
    logic [FRAME_W-1:0]    hit_slot;
    logic                  empty_any;
    logic [FRAME_W-1:0]    empty_slot;
    logic                  use_lru;
    logic [STAMP_W-1:0]    age0;
    logic [STAMP_W-1:0]    age_idx;
    logic [17:0]           div_prod;
    logic [6:0]            div_q;
    logic [ADDR_W-1:0]     div_q10;
    logic [ADDR_W-1:0]     addr_rem;
    logic [STAMP_W-1:0]    n_faults;
    logic [FRAME_W-1:0]    slot_next;
    logic [FRAME_W-1:0]    hand_next;

    // Lowest matching frame and lowest empty frame.
    always_comb begin
        hit_any    = 1'b0;
        hit_slot   = '0;
        empty_any  = 1'b0;
        empty_slot = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (r_frame_valid[i] && (r_frame_page[i] == r_page)) begin
                hit_any  = 1'b1;
                hit_slot = FRAME_W'(i);
            end
            if (!r_frame_valid[i]) begin
                empty_any  = 1'b1;
                empty_slot = FRAME_W'(i);
            end
        end
    end

    // Ages are taken modulo the stamp width, so wrapped stamps alias.
    assign use_lru = (r_policy == POLICY_LRU);
    assign age0    = use_lru ? (r_access_counter - r_last_use[0])
                             : (r_access_counter - r_load_time[0]);
    assign age_idx = use_lru ? (r_access_counter - r_last_use[r_idx])
                             : (r_access_counter - r_load_time[r_idx]);

    // Address modulo ten: the quotient is exact as (a * 205) >> 11 for a below 1029.
    assign div_prod = {8'd0, r_addr} * 18'd205;
    assign div_q    = div_prod[17:11];
    assign div_q10  = {div_q, 3'b000} + {2'b00, div_q, 1'b0};
    assign addr_rem = r_addr - div_q10;

    assign n_faults  = (r_faults == FAULT_MAX) ? r_faults : (r_faults + 1'b1);
    assign slot_next = (r_slot == FRAME_LAST) ? '0 : (r_slot + 1'b1);
    assign hand_next = (r_clock_hand == FRAME_LAST) ? '0 : (r_clock_hand + 1'b1);

    assign o_status.hit        = hit_any;
    assign o_status.found      = empty_any;
    assign o_status.clock_mode = (r_policy == POLICY_CLOCK);
    assign o_status.hand_ref   = r_ref_bit[r_clock_hand];
    assign o_status.scan_last  = (r_idx == FRAME_LAST);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid    <= '0;
            r_ref_bit        <= '0;
            r_clock_hand     <= '0;
            r_access_counter <= '0;
            r_faults         <= '0;
            r_policy         <= POLICY_FIFO;
        end else begin
            if (i_cfg_we) begin
                r_policy <= t_policy'(i_cfg_data);
            end
            if (i_cmd.load) begin
                r_access_counter <= r_access_counter + 1'b1;
            end
            // Second-chance sweep: a referenced frame loses its bit and the hand moves on.
            if (i_cmd.clock_step && r_ref_bit[r_clock_hand]) begin
                r_ref_bit[r_clock_hand] <= 1'b0;
                r_clock_hand            <= hand_next;
            end
            if (i_cmd.commit) begin
                r_ref_bit[r_slot] <= 1'b1;
                if (!r_hit) begin
                    r_frame_valid[r_slot] <= 1'b1;
                    r_faults              <= n_faults;
                    if (r_evict && (r_policy == POLICY_CLOCK)) begin
                        r_clock_hand <= slot_next;
                    end
                end
            end
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_instr_address;
            r_page <= i_page;
        end
        if (i_cmd.lookup) begin
            r_hit      <= hit_any;
            r_evict    <= !hit_any && !empty_any;
            // With every frame full the empty slot reads as frame zero, where the scan starts.
            r_slot     <= hit_any ? hit_slot : empty_slot;
            r_offset   <= addr_rem[OFFSET_W-1:0];
            r_idx      <= FRAME_W'(1);
            r_best_age <= age0;
        end
        if (i_cmd.scan_step) begin
            if (age_idx > r_best_age) begin
                r_best_age <= age_idx;
                r_slot     <= r_idx;
            end
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.clock_step && !r_ref_bit[r_clock_hand]) begin
            r_slot <= r_clock_hand;
        end
        if (i_cmd.commit) begin
            r_last_use[r_slot] <= r_access_counter;
            if (!r_hit) begin
                r_frame_page[r_slot] <= r_page;
                r_load_time[r_slot]  <= r_access_counter;
            end
            r_o_hit          <= r_hit;
            r_o_frame        <= FRAME_OUT_W'(r_slot);
            r_o_offset       <= r_offset;
            r_o_evicted      <= r_evict;
            r_o_evicted_page <= r_evict ? r_frame_page[r_slot] : '0;
            r_o_fault_count  <= r_hit ? r_faults : n_faults;
        end
    end

    assign o_hit          = r_o_hit;
    assign o_frame        = r_o_frame;
    assign o_offset       = r_o_offset;
    assign o_evicted      = r_o_evicted;
    assign o_evicted_page = r_o_evicted_page;
    assign o_fault_count  = r_o_fault_count;

endmodule

### hw/rtl/page_replacement_policy.sv
// ----------------------------------------------------------------------------
// Page replacement policy unit
// Resolves each memory access against a small frame table and, on a fault,
// fills an empty frame or replaces a victim chosen by FIFO, LRU or Clock.
//
//   Channel   Direction  Handshake               Payload
//   access    in         i_valid / o_ready       i_instr_address, i_page
//   result    out        o_valid / i_ready       o_hit, o_frame, o_offset,
//                                                o_evicted, o_evicted_page,
//                                                o_fault_count
//   config    in         i_cfg_we (no wait)      i_cfg_data (policy mode)
//
// A hit or a fill into an empty frame goes from lookup straight to commit.
// FIFO and LRU replacement add a scan over the other frames, one frame
// age compare per cycle; Clock replacement adds a hand sweep, one hand
// step per cycle. A result waits in the output register while the next
// access is taken; commit of that access waits until the register is free.
// Reset is synchronous and empties all frames.
// ----------------------------------------------------------------------------
module page_replacement_policy (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [prp_pkg::ADDR_W-1:0]          i_instr_address,
    input  logic [prp_pkg::PAGE_WIDTH-1:0]      i_page,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic [prp_pkg::FRAME_OUT_W-1:0]     o_frame,
    output logic [prp_pkg::OFFSET_W-1:0]        o_offset,
    output logic                                o_evicted,
    output logic [prp_pkg::PAGE_WIDTH-1:0]      o_evicted_page,
    output logic [prp_pkg::STAMP_W-1:0]         o_fault_count
);
    import prp_pkg::*;

    t_cmd    cmd;
    t_status status;

    prp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    prp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_instr_address (i_instr_address),
        .i_page          (i_page),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_hit           (o_hit),
        .o_frame         (o_frame),
        .o_offset        (o_offset),
        .o_evicted       (o_evicted),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

endmodule

### dv/page_replacement_policy_tb.sv
// ----------------------------------------------------------------------------
// Page replacement policy testbench
// Drives memory accesses through the page replacement unit under FIFO, LRU,
// Clock and the reserved policy code. A directed table covers frame fills,
// hits and the first evictions. Random phases follow, then a run of five
// pages cycling through four frames and a last random run under Clock. Each
// result is checked against its typed row or an in-bench frame table model.
// ----------------------------------------------------------------------------
module page_replacement_policy_tb;
    import prp_pkg::*;

    localparam int IDLE_PCT     = 18;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASES       = 7;
    localparam int PRINT_CAP    = 30;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame;
        logic [OFFSET_W-1:0]    offset;
        logic                   evicted;
        logic [PAGE_WIDTH-1:0]  evicted_page;
        logic [STAMP_W-1:0]     fault_count;
    } t_result;

    typedef enum logic { ROW_ACC, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_policy               policy;
        logic [ADDR_W-1:0]     addr;
        logic [PAGE_WIDTH-1:0] page;
        logic                  typed;
        t_result               want;
    } t_row;

    localparam t_result NO_WANT = '0;
    localparam int DIR_LEN = 25;

    // Rows with typed expectations follow the table from reset: fills into
    // empty frames, hits under FIFO and LRU, and the first FIFO eviction of page zero.
    localparam t_row DIR_ROWS [DIR_LEN] = '{
        '{ROW_ACC, POLICY_FIFO,  10'd0,    8'd0,   1'b1, '{1'b0, 2'd0, 4'd0, 1'b0, 8'd0, 16'd1}},
        '{ROW_ACC, POLICY_FIFO,  10'd1023, 8'd255, 1'b1, '{1'b0, 2'd1, 4'd3, 1'b0, 8'd0, 16'd2}},
        '{ROW_ACC, POLICY_FIFO,  10'd9,    8'd0,   1'b1, '{1'b1, 2'd0, 4'd9, 1'b0, 8'd0, 16'd2}},
        '{ROW_ACC, POLICY_FIFO,  10'd10,   8'h55,  1'b1, '{1'b0, 2'd2, 4'd0, 1'b0, 8'd0, 16'd3}},
        '{ROW_ACC, POLICY_FIFO,  10'd519,  8'hAA,  1'b1, '{1'b0, 2'd3, 4'd9, 1'b0, 8'd0, 16'd4}},
        '{ROW_ACC, POLICY_FIFO,  10'd5,    8'd7,   1'b1, '{1'b0, 2'd0, 4'd5, 1'b1, 8'd0, 16'd5}},
        '{ROW_CFG, POLICY_LRU,   10'd0,    8'd0,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_LRU,   10'd100,  8'd255, 1'b1, '{1'b1, 2'd1, 4'd0, 1'b0, 8'd0, 16'd5}},
        '{ROW_ACC, POLICY_LRU,   10'd2,    8'd1,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_LRU,   10'd512,  8'd2,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_LRU,   10'd256,  8'd7,   1'b0, NO_WANT},
        '{ROW_CFG, POLICY_CLOCK, 10'd0,    8'd0,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_CLOCK, 10'd128,  8'd3,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_CLOCK, 10'd64,   8'd1,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_CLOCK, 10'd32,   8'd4,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_CLOCK, 10'd16,   8'd5,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_CLOCK, 10'd8,    8'd3,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_CLOCK, 10'd4,    8'd6,   1'b0, NO_WANT},
        '{ROW_CFG, POLICY_RSVD,  10'd0,    8'd0,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_RSVD,  10'd1,    8'd8,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_RSVD,  10'd1022, 8'd9,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_RSVD,  10'd341,  8'd10,  1'b0, NO_WANT},
        '{ROW_CFG, POLICY_FIFO,  10'd0,    8'd0,   1'b0, NO_WANT},
        '{ROW_ACC, POLICY_FIFO,  10'd682,  8'd128, 1'b0, NO_WANT},
        '{ROW_ACC, POLICY_FIFO,  10'd999,  8'd255, 1'b0, NO_WANT}
    };

    localparam t_policy PHASE_POLICY [PHASES] = '{
        POLICY_LRU, POLICY_CLOCK, POLICY_FIFO, POLICY_RSVD,
        POLICY_CLOCK, POLICY_LRU, POLICY_FIFO
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [ADDR_W-1:0]     i_instr_address = '0;
    logic [PAGE_WIDTH-1:0] i_page = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_hit;
    logic [FRAME_OUT_W-1:0] o_frame;
    logic [OFFSET_W-1:0]   o_offset;
    logic                  o_evicted;
    logic [PAGE_WIDTH-1:0] o_evicted_page;
    logic [STAMP_W-1:0]    o_fault_count;

    page_replacement_policy dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_instr_address (i_instr_address),
        .i_page          (i_page),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_frame         (o_frame),
        .o_offset        (o_offset),
        .o_evicted       (o_evicted),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

    always #5 i_clk = ~i_clk;

    // Frame table mirror.
    logic [PAGE_WIDTH-1:0] fr_page   [FRAMES];
    logic                  fr_valid  [FRAMES];
    logic [STAMP_W-1:0]    fr_loaded [FRAMES];
    logic [STAMP_W-1:0]    fr_used   [FRAMES];
    logic                  fr_ref    [FRAMES];
    int                    hand;
    logic [STAMP_W-1:0]    tick;
    logic [STAMP_W-1:0]    fault_total;
    t_policy               mode;

    t_result pending_results [$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  n_accesses = 0;
    int  n_hits = 0;
    int  n_evictions = 0;
    int  stall_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    // Frame with the largest age by load time or by last use; ties go low.
    function automatic int oldest_frame(input bit by_use);
        int best;
        logic [STAMP_W-1:0] age, best_age;
        best = 0;
        best_age = tick - (by_use ? fr_used[0] : fr_loaded[0]);
        for (int i = 1; i < FRAMES; i++) begin
            age = tick - (by_use ? fr_used[i] : fr_loaded[i]);
            if (age > best_age) begin
                best_age = age;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic t_result resolve_access(input logic [ADDR_W-1:0] addr,
                                               input logic [PAGE_WIDTH-1:0] pg);
        t_result r;
        int slot;
        r = '0;
        slot = -1;
        tick = tick + 1'b1;
        n_accesses++;
        r.offset = OFFSET_W'(addr % 10);
        for (int i = 0; i < FRAMES; i++)
            if (slot < 0 && fr_valid[i] && fr_page[i] == pg)
                slot = i;
        if (slot >= 0) begin
            r.hit = 1'b1;
            fr_ref[slot] = 1'b1;
            fr_used[slot] = tick;
            n_hits++;
        end else begin
            for (int i = 0; i < FRAMES; i++)
                if (slot < 0 && !fr_valid[i])
                    slot = i;
            if (slot < 0) begin
                case (mode)
                    POLICY_LRU: begin
                        slot = oldest_frame(1'b1);
                    end
                    POLICY_CLOCK: begin
                        // Second chance: clear set reference bits until one is clear.
                        for (int s = 0; s <= FRAMES && slot < 0; s++) begin
                            if (!fr_ref[hand]) begin
                                slot = hand;
                            end else begin
                                fr_ref[hand] = 1'b0;
                                hand = (hand + 1) % FRAMES;
                            end
                        end
                        if (slot < 0)
                            slot = hand;
                        hand = (slot + 1) % FRAMES;
                    end
                    default: begin
                        slot = oldest_frame(1'b0);
                    end
                endcase
                r.evicted = 1'b1;
                r.evicted_page = fr_page[slot];
                n_evictions++;
            end
            fr_page[slot] = pg;
            fr_valid[slot] = 1'b1;
            fr_loaded[slot] = tick;
            fr_used[slot] = tick;
            fr_ref[slot] = 1'b1;
            if (fault_total != FAULT_MAX)
                fault_total = fault_total + 1'b1;
        end
        r.frame = FRAME_OUT_W'(slot);
        r.fault_count = fault_total;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            note_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                    results_seen, name, got, want));
    endtask

    task automatic send_access(input logic [ADDR_W-1:0] addr,
                               input logic [PAGE_WIDTH-1:0] pg,
                               input bit typed, input t_result want);
        t_result predicted;
        i_valid <= 1'b1;
        i_instr_address <= addr;
        i_page <= pg;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = resolve_access(addr, pg);
        pending_results.push_back(typed ? want : predicted);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int ws, input logic [PAGE_WIDTH-1:0] base);
        logic [PAGE_WIDTH-1:0] pg;
        if ($urandom_range(99) < 15)
            pg = PAGE_WIDTH'($urandom_range((1 << PAGE_WIDTH) - 1));
        else
            pg = base + PAGE_WIDTH'($urandom_range(ws - 1));
        send_access(ADDR_W'($urandom_range((1 << ADDR_W) - 1)), pg, 1'b0, NO_WANT);
    endtask

    // The policy register only changes with nothing in flight.
    task automatic set_policy(input t_policy p);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode = p;
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result %0d arrived with nothing expected",
                                        results_seen));
            end else begin
                want = pending_results.pop_front();
                check_field("hit", o_hit, want.hit);
                check_field("frame", o_frame, want.frame);
                check_field("offset", o_offset, want.offset);
                check_field("evicted", o_evicted, want.evicted);
                check_field("evicted_page", o_evicted_page, want.evicted_page);
                check_field("fault_count", o_fault_count, want.fault_count);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         stall_cycles, pending_results.size());
                $display("page_replacement_policy_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int ws;
        logic [PAGE_WIDTH-1:0] base;

        for (int i = 0; i < FRAMES; i++) begin
            fr_page[i] = '0;
            fr_valid[i] = 1'b0;
            fr_loaded[i] = '0;
            fr_used[i] = '0;
            fr_ref[i] = 1'b0;
        end
        hand = 0;
        tick = '0;
        fault_total = '0;
        mode = POLICY_FIFO;
        ws = 4;
        base = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // The first rows run under the policy left by reset.
        for (int k = 0; k < DIR_LEN; k++) begin
            if (DIR_ROWS[k].kind == ROW_CFG)
                set_policy(DIR_ROWS[k].policy);
            else
                send_access(DIR_ROWS[k].addr, DIR_ROWS[k].page,
                            DIR_ROWS[k].typed, DIR_ROWS[k].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            calm <= (ph == 2);
            set_policy(PHASE_POLICY[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Move the working set now and then so misses keep coming.
                if (n % 40 == 0) begin
                    ws = $urandom_range(8, 3);
                    base = PAGE_WIDTH'($urandom);
                end
                if (ph == 4 && n == 40)
                    hold_req <= 1'b1;
                send_random(ws, base);
            end
        end

        // Five pages cycling through four frames miss on every access.
        calm <= 1'b1;
        set_policy(POLICY_FIFO);
        for (int n = 0; n < 60; n++) begin
            send_access(ADDR_W'($urandom_range((1 << ADDR_W) - 1)),
                        PAGE_WIDTH'(8'hF0 + n % 5), 1'b0, NO_WANT);
        end

        calm <= 1'b0;
        set_policy(POLICY_CLOCK);
        for (int n = 0; n < 60; n++) begin
            if (n % 20 == 0)
                base = PAGE_WIDTH'($urandom);
            send_random(5, base);
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d accesses under all four policy codes: %0d hits, %0d evictions",
                 n_accesses, n_hits, n_evictions);
        $display("fault counter ended at %0d, %0d results compared, %0d mismatches",
                 fault_total, results_seen, mismatches);
        if (mismatches == 0)
            $display("page_replacement_policy_tb OK");
        else
            $display("page_replacement_policy_tb NOT OK");
        $finish;
    end

endmodule
